// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the quadrature position counter RTL.
// Each macro expects signals named clk and rst in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define QPC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qpc assertion failed");

// Next-cycle implication, disabled while reset is high.
`define QPC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qpc assertion failed");

`endif

// ===== hw/rtl/qpc_pkg.sv =====
// Shared constants for the quadrature position counter.
// Used by qpc_decode, qpc_scale and quadrature_position_counter_top; no dependencies.
package qpc_pkg;

  localparam int COUNT_BITS_DEF = 32;
  localparam int SCALE_W        = 20;
  localparam int POS_W          = 52;
  localparam int RAW_W          = 32;
  localparam int ZV_W           = 32;
  localparam int OP_W           = 2;
  localparam int CFG_IDX_W      = 1;

  localparam logic [OP_W-1:0] OP_SAMPLE   = 2'd0;
  localparam logic [OP_W-1:0] OP_ZERO_CUR = 2'd1;
  localparam logic [OP_W-1:0] OP_ZERO_VAL = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE      = 1'd1;

  localparam logic MODE_X1 = 1'b0;
  localparam logic MODE_X4 = 1'b1;

  localparam logic               MODE_RESET  = MODE_X4;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 20'd2000;

endpackage

// ===== hw/rtl/qpc_decode.sv =====
// Encoder decoder: keeps the count, zero point and previous pin levels.
// Depends on qpc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qpc_decode #(
  parameter int COUNT_BITS = qpc_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [qpc_pkg::OP_W-1:0]     op,
  input  logic                         pin_a,
  input  logic                         pin_b,
  input  logic signed [qpc_pkg::ZV_W-1:0] zero_value,
  input  logic                         count_mode,
  output logic [COUNT_BITS-1:0]        count,
  output logic [COUNT_BITS-1:0]        zero,
  output logic                         illegal
);

  logic                  last_a;
  logic                  last_b;
  logic                  last_seen;
  logic [COUNT_BITS-1:0] count_next;
  logic [COUNT_BITS-1:0] zero_next;
  logic                  last_a_next;
  logic                  last_b_next;
  logic                  last_seen_next;
  logic                  illegal_next;
  logic                  step_en;
  logic                  step_up;
  logic                  chg_a;
  logic                  chg_b;

  assign chg_a = pin_a != last_a;
  assign chg_b = pin_b != last_b;

  always_comb begin
    zero_next      = zero;
    last_a_next    = last_a;
    last_b_next    = last_b;
    last_seen_next = last_seen;
    illegal_next   = 1'b0;
    step_en        = 1'b0;
    step_up        = 1'b0;
    count_next     = count;
    case (op)
      qpc_pkg::OP_SAMPLE: begin
        last_a_next    = pin_a;
        last_b_next    = pin_b;
        last_seen_next = 1'b1;
        if (last_seen) begin
          if (count_mode == qpc_pkg::MODE_X1) begin
            step_en = !last_a && pin_a;
            step_up = !pin_b;
          end else if (chg_a && chg_b) begin
            illegal_next = 1'b1;
          end else if (chg_a) begin
            step_en = 1'b1;
            step_up = pin_a != pin_b;
          end else if (chg_b) begin
            step_en = 1'b1;
            step_up = pin_a == pin_b;
          end
        end
      end
      qpc_pkg::OP_ZERO_CUR: begin
        zero_next = count;
      end
      qpc_pkg::OP_ZERO_VAL: begin
        zero_next = COUNT_BITS'(zero_value);
      end
      default: begin
        last_a_next    = pin_a;
        last_b_next    = pin_b;
        last_seen_next = 1'b1;
      end
    endcase
    if (op == qpc_pkg::OP_CLEAR) begin
      count_next = '0;
    end else if (step_en) begin
      count_next = count + (step_up ? COUNT_BITS'(1) : {COUNT_BITS{1'b1}});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      zero      <= '0;
      last_a    <= 1'b0;
      last_b    <= 1'b0;
      last_seen <= 1'b0;
      illegal   <= 1'b0;
    end else if (accept) begin
      count     <= count_next;
      zero      <= zero_next;
      last_a    <= last_a_next;
      last_b    <= last_b_next;
      last_seen <= last_seen_next;
      illegal   <= illegal_next;
    end
  end

  `QPC_ASSERT_NEXT(a_clear_count, accept && op == qpc_pkg::OP_CLEAR, count == '0 && last_seen)
  `QPC_ASSERT_NEXT(a_first_sample, accept && !last_seen, !illegal && $stable(count))
  `QPC_ASSERT_NEXT(a_illegal_mode, accept && count_mode == qpc_pkg::MODE_X1, !illegal)

endmodule

// ===== hw/rtl/qpc_scale.sv =====
// Position pipeline: difference, magnitude, multiply by scale, saturate and sign.
// Depends on qpc_pkg.
module qpc_scale #(
  parameter int COUNT_BITS = qpc_pkg::COUNT_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [COUNT_BITS-1:0]              count,
  input  logic [COUNT_BITS-1:0]              zero,
  input  logic                               illegal,
  input  logic [qpc_pkg::SCALE_W-1:0]        scale,
  output logic signed [qpc_pkg::RAW_W-1:0]   raw_count,
  output logic signed [qpc_pkg::POS_W-1:0]   position_nm,
  output logic                               status,
  output logic                               illegal_step
);

  localparam int PW = COUNT_BITS + qpc_pkg::SCALE_W;
  localparam int LW = (PW > qpc_pkg::POS_W + 1) ? PW : qpc_pkg::POS_W + 1;
  localparam logic [LW-1:0] LIM_NEG = LW'(1) << (qpc_pkg::POS_W - 1);
  localparam logic [LW-1:0] LIM_POS = LIM_NEG - LW'(1);

  logic [COUNT_BITS-1:0] diff;
  logic [COUNT_BITS-1:0] s2_mag;
  logic                  s2_neg;
  logic [COUNT_BITS-1:0] s2_count;
  logic                  s2_illegal;
  logic [PW-1:0]         s3_prod;
  logic                  s3_neg;
  logic [COUNT_BITS-1:0] s3_count;
  logic                  s3_illegal;
  logic [LW-1:0]         prod_ext;
  logic [LW-1:0]         lim;
  logic [LW-1:0]         psat;
  logic [LW-1:0]         pos;

  assign diff     = count - zero;
  assign prod_ext = LW'(s3_prod);
  assign lim      = s3_neg ? LIM_NEG : LIM_POS;
  assign psat     = (prod_ext > lim) ? lim : prod_ext;
  assign pos      = s3_neg ? (LW'(0) - psat) : psat;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_neg       <= diff[COUNT_BITS-1];
      s2_mag       <= diff[COUNT_BITS-1] ? (COUNT_BITS'(0) - diff) : diff;
      s2_count     <= count;
      s2_illegal   <= illegal;
      s3_prod      <= PW'(s2_mag) * PW'(scale);
      s3_neg       <= s2_neg;
      s3_count     <= s2_count;
      s3_illegal   <= s2_illegal;
      raw_count    <= qpc_pkg::RAW_W'($signed(s3_count));
      position_nm  <= pos[qpc_pkg::POS_W-1:0];
      status       <= scale == '0;
      illegal_step <= s3_illegal;
    end
  end

endmodule

// ===== hw/rtl/quadrature_position_counter_top.sv =====
// Quadrature position counter, top level. A transaction passes through the decode,
// magnitude, multiply and saturate stages in order before its result is valid.
// Throughput: one transaction per cycle; the pipeline halts only while the output stalls.
// Reset (synchronous) clears count, zero and pin history, empties the pipeline, and sets
// count_mode to x4 and the scale to 2000 nm per count.
// Depends on qpc_pkg, qpc_decode, qpc_scale and assert_macros.svh.
`include "assert_macros.svh"

module quadrature_position_counter_top #(
  parameter int COUNT_BITS = qpc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [qpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qpc_pkg::SCALE_W-1:0]         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [qpc_pkg::OP_W-1:0]            op,
  input  logic                                pin_a,
  input  logic                                pin_b,
  input  logic signed [qpc_pkg::ZV_W-1:0]     zero_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qpc_pkg::RAW_W-1:0]    raw_count,
  output logic signed [qpc_pkg::POS_W-1:0]    position_nm,
  output logic                                status,
  output logic                                illegal_step
);

  logic                        count_mode;
  logic [qpc_pkg::SCALE_W-1:0] scale_nm_per_count;
  logic                        en;
  logic                        accept;
  logic                        v1;
  logic                        v2;
  logic                        v3;
  logic [COUNT_BITS-1:0]       count;
  logic [COUNT_BITS-1:0]       zero;
  logic                        illegal;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      count_mode         <= qpc_pkg::MODE_RESET;
      scale_nm_per_count <= qpc_pkg::SCALE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        qpc_pkg::CFG_COUNT_MODE: count_mode <= cfg_wdata[0];
        qpc_pkg::CFG_SCALE:      scale_nm_per_count <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  qpc_decode #(
    .COUNT_BITS(COUNT_BITS)
  ) u_decode (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .op         (op),
    .pin_a      (pin_a),
    .pin_b      (pin_b),
    .zero_value (zero_value),
    .count_mode (count_mode),
    .count      (count),
    .zero       (zero),
    .illegal    (illegal)
  );

  qpc_scale #(
    .COUNT_BITS(COUNT_BITS)
  ) u_scale (
    .clk          (clk),
    .en           (en),
    .count        (count),
    .zero         (zero),
    .illegal      (illegal),
    .scale        (scale_nm_per_count),
    .raw_count    (raw_count),
    .position_nm  (position_nm),
    .status       (status),
    .illegal_step (illegal_step)
  );

  `QPC_ASSERT_IMPL(a_status_scale, out_valid, status == (scale_nm_per_count == '0))
  `QPC_ASSERT_IMPL(a_invalid_pos, out_valid && status, position_nm == '0)
  `QPC_ASSERT_NEXT(a_pipe_advance, v3 && en, out_valid)

endmodule
